// ===== sv/goc_pkg.sv =====
// shared types, constants and helpers of the gaze offset calibrator
package goc_pkg;

  localparam int GOC_RING_DEPTH = 256;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_BYPASS = 3'd4;

  localparam logic [8:0]  WINDOW_COUNT_RST = 9'd150;
  localparam logic [15:0] SPAN_LIMIT_RST   = 16'd160;
  localparam logic [15:0] TARGET_RST       = 16'd2775;

  typedef struct packed {
    logic signed [15:0] gaze_x;
    logic signed [15:0] gaze_y;
    logic               face_present;
    logic               fresh_frame;
  } gaze_in_t;

  typedef struct packed {
    logic signed [15:0] corrected_x;
    logic signed [15:0] corrected_y;
    logic [15:0]        span_x;
    logic [15:0]        span_y;
    logic               is_calibrated;
    logic               calib_done;
  } gaze_out_t;

  typedef struct packed {
    logic accept;
    logic face_clr;
    logic addr_clr;
    logic clear_wr;
    logic ring_wr;
    logic scan_issue;
    logic div_load;
    logic div_step;
    logic apply;
    logic face_leave;
    logic out_load;
  } goc_cmd_t;

  typedef struct packed {
    logic bypass;
    logic face;
    logic fresh;
    logic face_seen;
    logic calibrated;
    logic clear_last;
    logic scan_last;
    logic div_last;
  } goc_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/gaze_offset_calibrator_unit.sv =====
// top level of the gaze offset calibrator
//
//   port group    dir   handshake              width
//   in_*          in    in_valid_i/in_ready_o   34-bit gaze_in_t beat
//   out_*         out   out_valid_o/out_ready_i 66-bit gaze_out_t beat
//   cfg_*         in    cfg_we_i, no wait       3-bit index, 16-bit data
//
// one beat at a time; a beat that skips calibration passes the check and finish states
// before its result is loaded, a bypassed beat goes from decide straight to the result load
// a calibrating beat's duration is set by the ring scan, one entry per cycle,
// and by the bit-serial divide
// a newly appearing face adds a clear of the whole ring
// after reset the whole ring is cleared before in_ready_o rises
// a stalled result waits in the output register while the next beat is taken
module gaze_offset_calibrator_unit #(
  parameter int RING_DEPTH = goc_pkg::GOC_RING_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  goc_pkg::gaze_in_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output goc_pkg::gaze_out_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [goc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [goc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import goc_pkg::*;

  goc_cmd_t    cmd;
  goc_status_t status;

  goc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  goc_datapath #(.RING_DEPTH(RING_DEPTH)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ===== sv/goc_div_lane.sv =====
// restoring divider lane, one quotient bit per step, divisor latched on load
module goc_div_lane #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 9
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic [DVS_W-1:0] remainder_o
);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             take;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    take  = (trial >= {1'b0, dvs_q});
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (load_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (step_i) begin
      quo_d = {quo_q[DVD_W-2:0], take};
      rem_d = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== sv/goc_datapath.sv =====
// datapath: config registers, sample ring, scan accumulators, dividers and result register
module goc_datapath #(
  parameter int RING_DEPTH = goc_pkg::GOC_RING_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [goc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [goc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  goc_pkg::gaze_in_t             in_data_i,
  input  goc_pkg::goc_cmd_t             cmd_i,
  output goc_pkg::goc_status_t          status_o,
  output goc_pkg::gaze_out_t            out_data_o
);
  import goc_pkg::*;

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = 16 + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);

  // config
  logic [8:0]         window_q;
  logic [15:0]        span_limit_q;
  logic signed [15:0] target_x_q, target_y_q;
  logic               bypass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= WINDOW_COUNT_RST;
      span_limit_q <= SPAN_LIMIT_RST;
      target_x_q   <= TARGET_RST;
      target_y_q   <= TARGET_RST;
      bypass_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_COUNT: window_q     <= cfg_wdata_i[8:0];
        CFG_SPAN_LIMIT:   span_limit_q <= cfg_wdata_i;
        CFG_TARGET_X:     target_x_q   <= cfg_wdata_i;
        CFG_TARGET_Y:     target_y_q   <= cfg_wdata_i;
        CFG_CALIB_BYPASS: bypass_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // effective window
  logic [CNT_W-1:0] win_n;
  always_comb begin
    if (window_q == 9'd0) begin
      win_n = CNT_W'(1);
    end else if (32'(window_q) > RING_DEPTH) begin
      win_n = CNT_W'(RING_DEPTH);
    end else begin
      win_n = CNT_W'(window_q);
    end
  end

  // calibration state
  gaze_in_t           in_q;
  logic signed [15:0] cx_q, cy_q;
  logic signed [15:0] shift_x_q, shift_y_q;
  logic               calib_q, face_seen_q, done_q;
  logic [IDX_W-1:0]   wp_q;
  logic [15:0]        span_x_q, span_y_q;

  // ring memory
  logic signed [15:0] ring_x [RING_DEPTH];
  logic signed [15:0] ring_y [RING_DEPTH];
  logic [IDX_W-1:0]   addr_q;
  logic signed [15:0] rd_x_q, rd_y_q;
  logic               rd_valid_q, rd_first_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic signed [15:0] mem_wx, mem_wy;

  always_comb begin
    mem_we = cmd_i.clear_wr || cmd_i.ring_wr;
    mem_wa = cmd_i.ring_wr ? wp_q : addr_q;
    mem_wx = cmd_i.ring_wr ? in_q.gaze_x : 16'sd0;
    mem_wy = cmd_i.ring_wr ? in_q.gaze_y : 16'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_x[mem_wa] <= mem_wx;
      ring_y[mem_wa] <= mem_wy;
    end
    rd_x_q <= ring_x[addr_q];
    rd_y_q <= ring_y[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      rd_valid_q <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan_issue;
      rd_first_q <= (addr_q == '0);
      if (cmd_i.addr_clr) begin
        addr_q <= '0;
      end else if (cmd_i.clear_wr || cmd_i.scan_issue) begin
        addr_q <= addr_q + 1'b1;
      end
    end
  end

  // scan accumulators
  logic signed [15:0]      mn_x_q, mx_x_q, mn_y_q, mx_y_q;
  logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
  logic signed [SUM_W-1:0] ext_x, ext_y;

  assign ext_x = {{(SUM_W-16){rd_x_q[15]}}, rd_x_q};
  assign ext_y = {{(SUM_W-16){rd_y_q[15]}}, rd_y_q};

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      if (rd_first_q) begin
        mn_x_q  <= rd_x_q;
        mx_x_q  <= rd_x_q;
        mn_y_q  <= rd_y_q;
        mx_y_q  <= rd_y_q;
        sum_x_q <= ext_x;
        sum_y_q <= ext_y;
      end else begin
        if (rd_x_q < mn_x_q) mn_x_q <= rd_x_q;
        if (rd_x_q > mx_x_q) mx_x_q <= rd_x_q;
        if (rd_y_q < mn_y_q) mn_y_q <= rd_y_q;
        if (rd_y_q > mx_y_q) mx_y_q <= rd_y_q;
        sum_x_q <= sum_x_q + ext_x;
        sum_y_q <= sum_y_q + ext_y;
      end
    end
  end

  // dividers
  logic             neg_x_q, neg_y_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic [SUM_W-1:0] mag_x, mag_y, pos_dvd;
  logic [SUM_W-1:0] q_x, q_y, q_pos;
  logic [CNT_W-1:0] r_x, r_y, r_pos;
  logic [CNT_W-1:0] wp_next;

  assign mag_x   = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
  assign mag_y   = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
  assign wp_next = CNT_W'(wp_q) + 1'b1;
  assign pos_dvd = SUM_W'(wp_next);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      neg_x_q   <= sum_x_q[SUM_W-1];
      neg_y_q   <= sum_y_q[SUM_W-1];
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  goc_div_lane #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_x (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (mag_x),
    .divisor_i  (win_n),
    .quotient_o (q_x),
    .remainder_o(r_x)
  );

  goc_div_lane #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_y (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (mag_y),
    .divisor_i  (win_n),
    .quotient_o (q_y),
    .remainder_o(r_y)
  );

  goc_div_lane #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_pos (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (pos_dvd),
    .divisor_i  (win_n),
    .quotient_o (q_pos),
    .remainder_o(r_pos)
  );

  // offset and span evaluation
  logic [SUM_W-1:0]   mean_x_full, mean_y_full;
  logic signed [17:0] off_x, off_y;
  logic [16:0]        dx, dy;
  logic               span_ok;
  logic signed [17:0] sum_cx, sum_cy;

  always_comb begin
    mean_x_full = neg_x_q ? (~q_x + 1'b1) : q_x;
    mean_y_full = neg_y_q ? (~q_y + 1'b1) : q_y;
    off_x = {{2{target_x_q[15]}}, target_x_q} - signed'(mean_x_full[17:0]);
    off_y = {{2{target_y_q[15]}}, target_y_q} - signed'(mean_y_full[17:0]);
    dx = {mx_x_q[15], mx_x_q} - {mn_x_q[15], mn_x_q};
    dy = {mx_y_q[15], mx_y_q} - {mn_y_q[15], mn_y_q};
    span_ok = (dx[15:0] <= span_limit_q) && (dy[15:0] <= span_limit_q);
    sum_cx = {{2{in_data_i.gaze_x[15]}}, in_data_i.gaze_x}
           + {{2{shift_x_q[15]}}, shift_x_q};
    sum_cy = {{2{in_data_i.gaze_y[15]}}, in_data_i.gaze_y}
           + {{2{shift_y_q[15]}}, shift_y_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q <= in_data_i;
      cx_q <= sat16(sum_cx);
      cy_q <= sat16(sum_cy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_x_q   <= '0;
      shift_y_q   <= '0;
      calib_q     <= 1'b0;
      face_seen_q <= 1'b0;
      done_q      <= 1'b0;
      wp_q        <= '0;
      span_x_q    <= '0;
      span_y_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        done_q <= 1'b0;
      end
      if (cmd_i.face_clr) begin
        shift_x_q   <= '0;
        shift_y_q   <= '0;
        calib_q     <= 1'b0;
        face_seen_q <= 1'b1;
        wp_q        <= '0;
        span_x_q    <= '0;
        span_y_q    <= '0;
      end
      if (cmd_i.apply) begin
        wp_q     <= r_pos[IDX_W-1:0];
        span_x_q <= dx[15:0];
        span_y_q <= dy[15:0];
        if (span_ok) begin
          shift_x_q <= sat16(off_x);
          shift_y_q <= sat16(off_y);
          calib_q   <= 1'b1;
          done_q    <= 1'b1;
        end
      end
      if (cmd_i.face_leave && !in_q.face_present) begin
        face_seen_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o.corrected_x   <= cx_q;
      out_data_o.corrected_y   <= cy_q;
      out_data_o.span_x        <= span_x_q;
      out_data_o.span_y        <= span_y_q;
      out_data_o.is_calibrated <= calib_q;
      out_data_o.calib_done    <= done_q;
    end
  end

  always_comb begin
    status_o.bypass     = bypass_q;
    status_o.face       = in_q.face_present;
    status_o.fresh      = in_q.fresh_frame;
    status_o.face_seen  = face_seen_q;
    status_o.calibrated = calib_q;
    status_o.clear_last = (addr_q == IDX_W'(RING_DEPTH - 1));
    status_o.scan_last  = (CNT_W'(addr_q) == (win_n - 1'b1));
    status_o.div_last   = (div_cnt_q == DCNT_W'(SUM_W - 1));
  end

endmodule

// ===== sv/goc_ctrl.sv =====
// controller: sequences clear, write, scan, divide and result handoff
module goc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  goc_pkg::goc_status_t status_i,
  output goc_pkg::goc_cmd_t    cmd_o
);
  import goc_pkg::*;

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECIDE   = 4'd2;
  localparam logic [3:0] S_WIPE     = 4'd3;
  localparam logic [3:0] S_CHECK    = 4'd4;
  localparam logic [3:0] S_WRITE    = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_SCAN_END = 4'd7;
  localparam logic [3:0] S_DIV_LOAD = 4'd8;
  localparam logic [3:0] S_DIV      = 4'd9;
  localparam logic [3:0] S_APPLY    = 4'd10;
  localparam logic [3:0] S_FINISH   = 4'd11;
  localparam logic [3:0] S_OUT      = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status_i.bypass) begin
          state_d = S_OUT;
        end else if (status_i.face && !status_i.face_seen) begin
          cmd_o.face_clr = 1'b1;
          cmd_o.addr_clr = 1'b1;
          state_d = S_WIPE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_WIPE: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.face && !status_i.calibrated && status_i.fresh) begin
          cmd_o.addr_clr = 1'b1;
          state_d = S_WRITE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_WRITE: begin
        cmd_o.ring_wr = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) state_d = S_SCAN_END;
      end
      S_SCAN_END: begin
        state_d = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.face_leave = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
